/* rtl/voxel_shape_classifier_defines.svh */
// assertion macros for the voxel shape classifier
`ifndef VOXEL_SHAPE_CLASSIFIER_DEFINES_SVH
`define VOXEL_SHAPE_CLASSIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked at every rising edge out of reset
`define VSC_ASSERT_COMB(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voxel shape classifier check failed");

// next-cycle implication
`define VSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voxel shape classifier check failed");

`else

`define VSC_ASSERT_COMB(lbl, ante, cons)
`define VSC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/vsc_pkg.sv */
// shared constants, types and codes of the voxel shape classifier
package vsc_pkg;

  // block constants
  localparam int CHUNK_LOG  = 5;
  localparam int MAX_EXTENT = 1024;

  // field widths
  localparam int COORD_W = 24;
  localparam int CHUNK_W = 19;
  localparam int LOCAL_W = 5;
  localparam int SHAPE_W = 3;
  localparam int CFG_IDX_W = 3;

  // datapath widths, sized for extents up to 1024
  localparam int EXT_W    = COORD_W + 1;        // raw extent hi - lo + 1
  localparam int SIZE_W   = 11;                 // extent when in range
  localparam int MAG_W    = 10;                 // |d| <= size - 1
  localparam int DOFF_W   = SIZE_W + 2;         // signed d
  localparam int DSQ_W    = 2 * MAG_W;          // d squared
  localparam int SQ_W     = 21;                 // size squared
  localparam int PAIR_W   = 2 * SQ_W;           // product of two size squares
  localparam int HALF_W   = SQ_W;               // half of a pair product
  localparam int CYL_W    = DSQ_W + SQ_W;       // cylinder term
  localparam int PART_W   = DSQ_W + HALF_W;     // ellipsoid partial product
  localparam int TPART_W  = SQ_W + HALF_W;      // total partial product
  localparam int TERM_W   = DSQ_W + PAIR_W;     // ellipsoid term
  localparam int TOT_W    = SQ_W + PAIR_W;      // product of all size squares
  localparam int SUM_W    = TOT_W + 1;          // sum of three terms

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [CHUNK_W-1:0] chunk_t;
  typedef logic [LOCAL_W-1:0]        local_t;
  typedef logic [SHAPE_W-1:0]        shape_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [DSQ_W-1:0]          dsq_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [TERM_W-1:0]         term_t;
  typedef logic [TOT_W-1:0]          tot_t;

  // shape codes
  localparam shape_t SHAPE_BOX       = 3'd0;
  localparam shape_t SHAPE_ELLIPSOID = 3'd1;
  localparam shape_t SHAPE_CYL_Z     = 3'd2;
  localparam shape_t SHAPE_CYL_Y     = 3'd3;
  localparam shape_t SHAPE_CYL_X     = 3'd4;

  // register indexes
  localparam cfg_idx_t REG_CORNER_A_X = 3'd0;
  localparam cfg_idx_t REG_CORNER_A_Y = 3'd1;
  localparam cfg_idx_t REG_CORNER_A_Z = 3'd2;
  localparam cfg_idx_t REG_CORNER_B_X = 3'd3;
  localparam cfg_idx_t REG_CORNER_B_Y = 3'd4;
  localparam cfg_idx_t REG_CORNER_B_Z = 3'd5;
  localparam cfg_idx_t REG_SHAPE_KIND = 3'd6;

  // stage load enables of the per-axis front end
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } axis_en_t;

  // stage load enables of the product stages
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
  } prod_en_t;

  // side data that travels with each request
  typedef struct packed {
    chunk_t chunk_x;
    chunk_t chunk_y;
    chunk_t chunk_z;
    local_t local_x;
    local_t local_y;
    local_t local_z;
    shape_t shape;
    logic   err;
    logic   inbox;
  } meta_t;

endpackage

/* rtl/voxel_shape_classifier.sv */
// top level of the voxel shape classifier: config registers, pipeline control, result stage
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_voxel_x, in_voxel_y, in_voxel_z
//   out      output     out_valid/out_stall  inside, extent error, chunk and local x/y/z
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// seven register stages, request to result; one request enters per cycle unless stalled
// the depth is set by the ellipsoid products of up to 63 bits, split into halves
// reset clears the config registers and all valid bits; cfg_ready is always high
// a stalled result holds; bubbles in the pipe still take new requests during a stall
module voxel_shape_classifier (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vsc_pkg::coord_t   in_voxel_x,
  input  vsc_pkg::coord_t   in_voxel_y,
  input  vsc_pkg::coord_t   in_voxel_z,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_inside_res,
  output logic              out_extent_error,
  output vsc_pkg::chunk_t   out_chunk_x,
  output vsc_pkg::chunk_t   out_chunk_y,
  output vsc_pkg::chunk_t   out_chunk_z,
  output vsc_pkg::local_t   out_local_x,
  output vsc_pkg::local_t   out_local_y,
  output vsc_pkg::local_t   out_local_z,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  vsc_pkg::cfg_idx_t cfg_index,
  input  vsc_pkg::coord_t   cfg_wdata
);
  import vsc_pkg::*;

  `include "voxel_shape_classifier_defines.svh"

  localparam int NSTG = 7;

  coord_t corner_a_r [3];
  coord_t corner_b_r [3];
  shape_t shape_kind_r;
  logic   shape_wr;

  logic [NSTG:1] vld_r;
  logic [NSTG:1] rdy;

  meta_t  meta_r   [1:NSTG-1];
  meta_t  meta_nxt [1:NSTG-1];

  coord_t   pin [3];
  axis_en_t axis_en;
  prod_en_t prod_en;
  dsq_t     dsq [3];
  sq_t      s2 [3];
  logic [2:0] ax_inbox;
  logic [2:0] ax_err;
  term_t    term [3];
  tot_t     tot;
  logic [2:0] cyl;

  logic [SUM_W-1:0] ell_sum;
  logic             ell_in;
  logic             shape_in;
  logic             inside_nxt;
  logic             inside_r;
  logic             err_r;
  chunk_t           chunk_r [3];
  local_t           local_r [3];

  // config writes
  assign cfg_ready = 1'b1;
  assign shape_wr  = cfg_valid && cfg_ready && (cfg_index == REG_SHAPE_KIND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        corner_a_r[i] <= '0;
        corner_b_r[i] <= '0;
      end
      shape_kind_r <= SHAPE_BOX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CORNER_A_X: corner_a_r[0] <= cfg_wdata;
        REG_CORNER_A_Y: corner_a_r[1] <= cfg_wdata;
        REG_CORNER_A_Z: corner_a_r[2] <= cfg_wdata;
        REG_CORNER_B_X: corner_b_r[0] <= cfg_wdata;
        REG_CORNER_B_Y: corner_b_r[1] <= cfg_wdata;
        REG_CORNER_B_Z: corner_b_r[2] <= cfg_wdata;
        REG_SHAPE_KIND: shape_kind_r  <= cfg_wdata[SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  // stall chain: a stage loads when empty or when the next one loads
  always_comb begin
    rdy[NSTG] = !vld_r[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // per-axis front end
  assign pin[0] = in_voxel_x;
  assign pin[1] = in_voxel_y;
  assign pin[2] = in_voxel_z;

  assign axis_en = '{s1: rdy[1], s2: rdy[2], s3: rdy[3]};
  assign prod_en = '{s4: rdy[4], s5: rdy[5], s6: rdy[6]};

  for (genvar g = 0; g < 3; g++) begin : g_axis
    vsc_axis u_axis (
      .clk   (clk),
      .en    (axis_en),
      .p     (pin[g]),
      .ca    (corner_a_r[g]),
      .cb    (corner_b_r[g]),
      .dsq   (dsq[g]),
      .s2    (s2[g]),
      .inbox (ax_inbox[g]),
      .err   (ax_err[g])
    );
  end

  vsc_prod u_prod (
    .clk  (clk),
    .en   (prod_en),
    .dsq  (dsq),
    .s2   (s2),
    .term (term),
    .tot  (tot),
    .cyl  (cyl)
  );

  // side data: chunk split at entry, box flags joined after stage 3
  always_comb begin
    meta_nxt[1].chunk_x = CHUNK_W'(in_voxel_x >>> CHUNK_LOG);
    meta_nxt[1].chunk_y = CHUNK_W'(in_voxel_y >>> CHUNK_LOG);
    meta_nxt[1].chunk_z = CHUNK_W'(in_voxel_z >>> CHUNK_LOG);
    meta_nxt[1].local_x = LOCAL_W'(in_voxel_x & ((COORD_W'(1) << CHUNK_LOG) - COORD_W'(1)));
    meta_nxt[1].local_y = LOCAL_W'(in_voxel_y & ((COORD_W'(1) << CHUNK_LOG) - COORD_W'(1)));
    meta_nxt[1].local_z = LOCAL_W'(in_voxel_z & ((COORD_W'(1) << CHUNK_LOG) - COORD_W'(1)));
    meta_nxt[1].shape   = shape_kind_r;
    meta_nxt[1].err     = 1'b0;
    meta_nxt[1].inbox   = 1'b0;
    for (int k = 2; k <= NSTG - 1; k++) begin
      meta_nxt[k] = meta_r[k-1];
    end
    meta_nxt[4].err   = |ax_err;
    meta_nxt[4].inbox = &ax_inbox;
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NSTG - 1; k++) begin
      if (rdy[k]) begin
        meta_r[k] <= meta_nxt[k];
      end
    end
  end

  // stage 7: ellipsoid sum and compare, shape select
  always_comb begin
    ell_sum = SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2]);
    ell_in  = ell_sum <= SUM_W'(tot);
    case (meta_r[NSTG-1].shape)
      SHAPE_BOX:       shape_in = 1'b1;
      SHAPE_ELLIPSOID: shape_in = ell_in;
      SHAPE_CYL_Z:     shape_in = cyl[0];
      SHAPE_CYL_Y:     shape_in = cyl[1];
      SHAPE_CYL_X:     shape_in = cyl[2];
      default:         shape_in = 1'b0;
    endcase
    inside_nxt = !meta_r[NSTG-1].err && meta_r[NSTG-1].inbox && shape_in;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      inside_r   <= inside_nxt;
      err_r      <= meta_r[NSTG-1].err;
      chunk_r[0] <= meta_r[NSTG-1].chunk_x;
      chunk_r[1] <= meta_r[NSTG-1].chunk_y;
      chunk_r[2] <= meta_r[NSTG-1].chunk_z;
      local_r[0] <= meta_r[NSTG-1].local_x;
      local_r[1] <= meta_r[NSTG-1].local_y;
      local_r[2] <= meta_r[NSTG-1].local_z;
    end
  end

  assign out_inside_res   = inside_r;
  assign out_extent_error = err_r;
  assign out_chunk_x      = chunk_r[0];
  assign out_chunk_y      = chunk_r[1];
  assign out_chunk_z      = chunk_r[2];
  assign out_local_x      = local_r[0];
  assign out_local_y      = local_r[1];
  assign out_local_z      = local_r[2];

  // checks
  `VSC_ASSERT_COMB(a_no_stall_when_out_free, !out_stall, !in_stall)
  `VSC_ASSERT_COMB(a_error_forces_outside, out_valid && out_extent_error, !out_inside_res)
  `VSC_ASSERT_NEXT(a_shape_write, shape_wr, shape_kind_r == $past(cfg_wdata[SHAPE_W-1:0]))

endmodule

/* rtl/vsc_axis.sv */
// per-axis front end: corner sort, box test, offset and squares (stages 1 to 3)
module vsc_axis (
  input  logic             clk,
  input  vsc_pkg::axis_en_t en,
  input  vsc_pkg::coord_t  p,
  input  vsc_pkg::coord_t  ca,
  input  vsc_pkg::coord_t  cb,
  output vsc_pkg::dsq_t    dsq,
  output vsc_pkg::sq_t     s2,
  output logic             inbox,
  output logic             err
);
  import vsc_pkg::*;

  coord_t                  lo;
  coord_t                  hi;
  logic [EXT_W-1:0]        ext;
  logic [EXT_W-1:0]        diff;
  logic signed [DOFF_W-1:0] d;
  logic signed [DOFF_W-1:0] mag;

  logic [SIZE_W-1:0] diff_r;
  logic [EXT_W-1:0]  ext_r;
  logic              inbox1_r;
  logic [MAG_W-1:0]  mag_r;
  logic [SIZE_W-1:0] size_r;
  logic              inbox2_r;
  logic              err2_r;
  dsq_t              dsq_r;
  sq_t               s2_r;
  logic              inbox3_r;
  logic              err3_r;

  // stage 1: sort corners, extent, box test, offset from low corner
  always_comb begin
    lo   = (ca < cb) ? ca : cb;
    hi   = (ca < cb) ? cb : ca;
    ext  = EXT_W'({hi[COORD_W-1], hi} - {lo[COORD_W-1], lo} + EXT_W'(1));
    diff = EXT_W'({p[COORD_W-1], p} - {lo[COORD_W-1], lo});
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      diff_r   <= diff[SIZE_W-1:0];
      ext_r    <= ext;
      inbox1_r <= (p >= lo) && (p <= hi);
    end
  end

  // stage 2: range check and |2p + 1 - 2lo - size|
  always_comb begin
    d   = $signed({1'b0, diff_r, 1'b1}) - $signed({2'b00, ext_r[SIZE_W-1:0]});
    mag = (d < 0) ? -d : d;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      mag_r    <= mag[MAG_W-1:0];
      size_r   <= ext_r[SIZE_W-1:0];
      inbox2_r <= inbox1_r;
      err2_r   <= ext_r > EXT_W'(MAX_EXTENT);
    end
  end

  // stage 3: squares of offset and extent
  always_ff @(posedge clk) begin
    if (en.s3) begin
      dsq_r    <= DSQ_W'(mag_r) * DSQ_W'(mag_r);
      s2_r     <= SQ_W'(SQ_W'(size_r) * SQ_W'(size_r));
      inbox3_r <= inbox2_r;
      err3_r   <= err2_r;
    end
  end

  assign dsq   = dsq_r;
  assign s2    = s2_r;
  assign inbox = inbox3_r;
  assign err   = err3_r;

endmodule

/* rtl/vsc_prod.sv */
// cross products of the round test: cylinder compares and ellipsoid terms (stages 4 to 6)
module vsc_prod (
  input  logic              clk,
  input  vsc_pkg::prod_en_t en,
  input  vsc_pkg::dsq_t     dsq [3],
  input  vsc_pkg::sq_t      s2 [3],
  output vsc_pkg::term_t    term [3],
  output vsc_pkg::tot_t     tot,
  output logic [2:0]        cyl
);
  import vsc_pkg::*;

  // stage 4 registers
  logic [PAIR_W-1:0] p01_r;
  logic [PAIR_W-1:0] p02_r;
  logic [PAIR_W-1:0] p12_r;
  logic [CYL_W-1:0]  cz_a_r, cz_b_r, cy_a_r, cy_b_r, cx_a_r, cx_b_r;
  dsq_t              dsq4_r [3];
  sq_t               s20_r;

  // stage 5 registers
  logic [2:0]         cyl5_r;
  logic [PART_W-1:0]  pe_lo_r [3];
  logic [PART_W-1:0]  pe_hi_r [3];
  logic [TPART_W-1:0] pt_lo_r;
  logic [TPART_W-1:0] pt_hi_r;

  // stage 6 registers
  term_t      term_r [3];
  tot_t       tot_r;
  logic [2:0] cyl6_r;

  logic [PAIR_W-1:0] pair [3];

  // stage 4: size-square pair products and cylinder terms
  always_ff @(posedge clk) begin
    if (en.s4) begin
      p01_r  <= PAIR_W'(s2[0]) * PAIR_W'(s2[1]);
      p02_r  <= PAIR_W'(s2[0]) * PAIR_W'(s2[2]);
      p12_r  <= PAIR_W'(s2[1]) * PAIR_W'(s2[2]);
      cz_a_r <= CYL_W'(dsq[0]) * CYL_W'(s2[1]);
      cz_b_r <= CYL_W'(dsq[1]) * CYL_W'(s2[0]);
      cy_a_r <= CYL_W'(dsq[0]) * CYL_W'(s2[2]);
      cy_b_r <= CYL_W'(dsq[2]) * CYL_W'(s2[0]);
      cx_a_r <= CYL_W'(dsq[1]) * CYL_W'(s2[2]);
      cx_b_r <= CYL_W'(dsq[2]) * CYL_W'(s2[1]);
      s20_r  <= s2[0];
      for (int i = 0; i < 3; i++) begin
        dsq4_r[i] <= dsq[i];
      end
    end
  end

  // pair product that goes with each axis offset
  always_comb begin
    pair[0] = p12_r;
    pair[1] = p02_r;
    pair[2] = p01_r;
  end

  // stage 5: cylinder compares, split products for the ellipsoid
  always_ff @(posedge clk) begin
    if (en.s5) begin
      cyl5_r[0] <= (PAIR_W'(cz_a_r) + PAIR_W'(cz_b_r)) <= p01_r;
      cyl5_r[1] <= (PAIR_W'(cy_a_r) + PAIR_W'(cy_b_r)) <= p02_r;
      cyl5_r[2] <= (PAIR_W'(cx_a_r) + PAIR_W'(cx_b_r)) <= p12_r;
      for (int i = 0; i < 3; i++) begin
        pe_lo_r[i] <= PART_W'(dsq4_r[i]) * PART_W'(pair[i][HALF_W-1:0]);
        pe_hi_r[i] <= PART_W'(dsq4_r[i]) * PART_W'(pair[i][PAIR_W-1:HALF_W]);
      end
      pt_lo_r <= TPART_W'(s20_r) * TPART_W'(p12_r[HALF_W-1:0]);
      pt_hi_r <= TPART_W'(s20_r) * TPART_W'(p12_r[PAIR_W-1:HALF_W]);
    end
  end

  // stage 6: recombine the split products
  always_ff @(posedge clk) begin
    if (en.s6) begin
      for (int i = 0; i < 3; i++) begin
        term_r[i] <= TERM_W'(pe_lo_r[i]) + (TERM_W'(pe_hi_r[i]) << HALF_W);
      end
      tot_r  <= TOT_W'(pt_lo_r) + (TOT_W'(pt_hi_r) << HALF_W);
      cyl6_r <= cyl5_r;
    end
  end

  assign term = term_r;
  assign tot  = tot_r;
  assign cyl  = cyl6_r;

endmodule
